>>> hdl/per_wheel_traction_control_assert.svh
// Assertion macros used by the traction control checker.
`ifndef PER_WHEEL_TRACTION_CONTROL_ASSERT_SVH
`define PER_WHEEL_TRACTION_CONTROL_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define PWTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("traction control check failed");

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define PWTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("traction control check failed");

`endif

>>> hdl/pwtc_pkg.sv
// Package with types, constants and register codes of the traction control block.
`default_nettype none

package pwtc_pkg;

    localparam int unsigned WHEEL_COUNT = 4;

    typedef logic [15:0] speed_t;
    typedef logic [15:0] red_t;
    typedef logic [16:0] scale_t;
    typedef logic [3:0]  wheel_mask_t;
    typedef logic [31:0] count_t;
    typedef logic [7:0]  pct_t;
    typedef logic [19:0] rate_t;
    typedef logic [9:0]  dt_t;
    typedef logic [29:0] decay_prod_t;

    // Register map, byte address = 4 * index.
    typedef enum logic [2:0] {
        REG_SLIP_THRESHOLD = 3'd0,
        REG_INITIAL_RED    = 3'd1,
        REG_STEP_RED       = 3'd2,
        REG_MAX_RED        = 3'd3,
        REG_RECOVERY_RATE  = 3'd4
    } reg_index_t;

    localparam pct_t   RST_SLIP_THRESHOLD = 8'd15;
    localparam red_t   RST_INITIAL_RED    = 16'd13107;
    localparam red_t   RST_STEP_RED       = 16'd3277;
    localparam red_t   RST_MAX_RED        = 16'd52429;
    localparam rate_t  RST_RECOVERY_RATE  = 20'd32768;

    localparam speed_t REF_MIN_SPEED = 16'd300;     // 3 km/h
    localparam red_t   ONSET_LIMIT   = 16'd655;     // just under 0.01 in Q0.16
    localparam dt_t    DT_DEFAULT_MS = 10'd10;
    localparam logic [15:0] DT_MAX_MS = 16'd1000;
    localparam scale_t SCALE_ONE     = 17'h10000;
    localparam logic [23:0] PCT_SCALE = 24'd100;
    localparam decay_prod_t ROUND_HALF = 30'd500;

    // floor(n / 125) = (n * RECIP_125) >> RECIP_SHIFT, exact for n < 2**27.
    localparam logic [27:0] RECIP_125   = 28'd137438954;
    localparam int unsigned RECIP_SHIFT = 34;

endpackage

`default_nettype wire

>>> hdl/per_wheel_traction_control.sv
// Per-wheel traction control slip limiter, top level.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    speeds, mask, enable, elapsed_ms, scales
//   output    out        out_valid / out_ready  scales, slipping_wheels, engaged, total
//   config    in         APB psel/penable       five registers at 4*index, pready tied high
//
// One transaction enters per cycle while in_ready is high; the accepting edge loads the
// input register, and the result register loads from it, raising out_valid, once it is
// empty or its transaction leaves. The path between the two registers holds the median
// and slip compare, one reciprocal multiply for the decay and the clamps.
// Reset clears control state, reductions, the activation counter and loads the
// register defaults. A stalled result holds its register while one more transaction
// waits in the input register; in_ready drops only when both are full.
`default_nettype none

module per_wheel_traction_control (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pwtc_pkg::speed_t   speed_fl,
    input  wire pwtc_pkg::speed_t   speed_fr,
    input  wire pwtc_pkg::speed_t   speed_rl,
    input  wire pwtc_pkg::speed_t   speed_rr,
    input  wire pwtc_pkg::wheel_mask_t eligible_mask,
    input  wire logic               control_enabled,
    input  wire logic [15:0]        elapsed_ms,
    input  wire pwtc_pkg::scale_t   scale_in_fl,
    input  wire pwtc_pkg::scale_t   scale_in_fr,
    input  wire pwtc_pkg::scale_t   scale_in_rl,
    input  wire pwtc_pkg::scale_t   scale_in_rr,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pwtc_pkg::scale_t        scale_out_fl,
    output pwtc_pkg::scale_t        scale_out_fr,
    output pwtc_pkg::scale_t        scale_out_rl,
    output pwtc_pkg::scale_t        scale_out_rr,
    output pwtc_pkg::wheel_mask_t   slipping_wheels,
    output logic                    tcs_engaged,
    output pwtc_pkg::count_t        activation_total,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import pwtc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    pct_t  slip_threshold_reg;
    red_t  initial_red_reg;
    red_t  step_red_reg;
    red_t  max_red_reg;
    rate_t recovery_rate_reg;

    reg_index_t cfg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slip_threshold_reg <= RST_SLIP_THRESHOLD;
            initial_red_reg    <= RST_INITIAL_RED;
            step_red_reg       <= RST_STEP_RED;
            max_red_reg        <= RST_MAX_RED;
            recovery_rate_reg  <= RST_RECOVERY_RATE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLIP_THRESHOLD: slip_threshold_reg <= pwdata[7:0];
                REG_INITIAL_RED:    initial_red_reg    <= pwdata[15:0];
                REG_STEP_RED:       step_red_reg       <= pwdata[15:0];
                REG_MAX_RED:        max_red_reg        <= pwdata[15:0];
                REG_RECOVERY_RATE:  recovery_rate_reg  <= pwdata[19:0];
                default:            ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_SLIP_THRESHOLD: prdata = {24'd0, slip_threshold_reg};
            REG_INITIAL_RED:    prdata = {16'd0, initial_red_reg};
            REG_STEP_RED:       prdata = {16'd0, step_red_reg};
            REG_MAX_RED:        prdata = {16'd0, max_red_reg};
            REG_RECOVERY_RATE:  prdata = {12'd0, recovery_rate_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds result register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic in_take;

    // The result register frees up when empty or when its transaction leaves.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Input register. The decay numerator rate * dt + 0.5 s is formed here
    // so that the next stage only has to divide it by 1000.
    // ------------------------------------------------------------------
    speed_t [WHEEL_COUNT-1:0] speed_reg;
    scale_t [WHEEL_COUNT-1:0] scale_in_reg;
    wheel_mask_t              mask_reg;
    logic                     enabled_reg;
    decay_prod_t              decay_num_reg;

    dt_t         dt_eff;
    decay_prod_t decay_num_next;

    // Fall back to 10 ms on a zero or out-of-range interval.
    assign dt_eff = (elapsed_ms == 16'd0 || elapsed_ms > DT_MAX_MS) ?
                    DT_DEFAULT_MS : elapsed_ms[9:0];
    assign decay_num_next = decay_prod_t'(recovery_rate_reg) * decay_prod_t'(dt_eff)
                            + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            speed_reg     <= {speed_rr, speed_rl, speed_fr, speed_fl};
            scale_in_reg  <= {scale_in_rr, scale_in_rl, scale_in_fr, scale_in_fl};
            mask_reg      <= eligible_mask;
            enabled_reg   <= control_enabled;
            decay_num_reg <= decay_num_next;
        end
    end

    // ------------------------------------------------------------------
    // Work stage
    // ------------------------------------------------------------------

    // Median of three speeds.
    function automatic speed_t med3(input speed_t a, input speed_t b, input speed_t c);
        speed_t lo;
        speed_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            return lo;
        else if (c >= hi)
            return hi;
        else
            return c;
    endfunction

    // Reference speed for one wheel from the eligible other wheels:
    // median of three, lower of two, the single one, or zero.
    function automatic speed_t ref_speed(input wheel_mask_t mask,
                                         input speed_t [WHEEL_COUNT-1:0] spd,
                                         input logic [1:0] skip);
        speed_t [2:0] oth;
        logic   [2:0] ov;
        logic   [1:0] k;
        speed_t       r;
        for (int j = 0; j < 3; j++)
        begin
            k      = (2'(j) < skip) ? 2'(j) : 2'(j) + 2'd1;
            oth[j] = spd[k];
            ov[j]  = mask[k];
        end
        unique case (ov)
            3'b000: r = 16'd0;
            3'b001: r = oth[0];
            3'b010: r = oth[1];
            3'b100: r = oth[2];
            3'b011: r = (oth[0] < oth[1]) ? oth[0] : oth[1];
            3'b101: r = (oth[0] < oth[2]) ? oth[0] : oth[2];
            3'b110: r = (oth[1] < oth[2]) ? oth[1] : oth[2];
            3'b111: r = med3(oth[0], oth[1], oth[2]);
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    red_t   [WHEEL_COUNT-1:0] wheel_red_reg;
    red_t   [WHEEL_COUNT-1:0] wheel_red_next;
    count_t                   activation_count_reg;
    count_t                   activation_count_next;
    scale_t [WHEEL_COUNT-1:0] scale_out_reg;
    scale_t [WHEEL_COUNT-1:0] scale_out_next;
    wheel_mask_t              slip_mask_reg;
    wheel_mask_t              slip_mask_next;

    logic [54:0] recip_prod;
    logic [20:0] decay_step;

    // Round-to-nearest rate * dt / 1000: drop three bits, then divide by 125.
    assign recip_prod = {28'd0, decay_num_reg[29:3]} * {27'd0, RECIP_125};
    assign decay_step = recip_prod[54:RECIP_SHIFT];

    speed_t [WHEEL_COUNT-1:0] ref_w;
    speed_t [WHEEL_COUNT-1:0] diff_w;
    logic   [WHEEL_COUNT-1:0] active_w;
    logic   [16:0]            grow_sum;
    red_t                     grown;
    red_t                     decayed;
    scale_t                   limit;

    always_comb
    begin
        grow_sum = 17'd0;
        grown    = 16'd0;
        decayed  = 16'd0;
        limit    = 17'd0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            active_w[w] = enabled_reg && mask_reg[w];
            ref_w[w]    = ref_speed(mask_reg, speed_reg, 2'(w));
            diff_w[w]   = speed_reg[w] - ref_w[w];

            slip_mask_next[w] = active_w[w] && (ref_w[w] >= REF_MIN_SPEED) &&
                                (speed_reg[w] > ref_w[w]) &&
                                ((24'(diff_w[w]) * PCT_SCALE) >
                                 (24'(slip_threshold_reg) * 24'(ref_w[w])));

            // Onset jumps to the initial value, otherwise add a step; clamp at max.
            grow_sum = (wheel_red_reg[w] <= ONSET_LIMIT) ? {1'b0, initial_red_reg} :
                       {1'b0, wheel_red_reg[w]} + {1'b0, step_red_reg};
            grown    = (grow_sum > {1'b0, max_red_reg}) ? max_red_reg : grow_sum[15:0];

            // Decay toward zero without slip.
            decayed  = (decay_step >= 21'(wheel_red_reg[w])) ? 16'd0 :
                       wheel_red_reg[w] - decay_step[15:0];

            if (!active_w[w])
                wheel_red_next[w] = 16'd0;
            else if (slip_mask_next[w])
                wheel_red_next[w] = grown;
            else
                wheel_red_next[w] = decayed;

            limit = SCALE_ONE - {1'b0, wheel_red_next[w]};
            scale_out_next[w] = (active_w[w] && (limit < scale_in_reg[w])) ?
                                limit : scale_in_reg[w];
        end

        // Count updates with any slip, saturating.
        activation_count_next = activation_count_reg;
        if (enabled_reg && (slip_mask_next != 4'd0) && (activation_count_reg != '1))
            activation_count_next = activation_count_reg + 32'd1;
    end

    // State advances together with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_red_reg        <= '0;
            activation_count_reg <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            wheel_red_reg        <= wheel_red_next;
            activation_count_reg <= activation_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            scale_out_reg <= scale_out_next;
            slip_mask_reg <= slip_mask_next;
        end
    end

    assign scale_out_fl     = scale_out_reg[0];
    assign scale_out_fr     = scale_out_reg[1];
    assign scale_out_rl     = scale_out_reg[2];
    assign scale_out_rr     = scale_out_reg[3];
    assign slipping_wheels  = slip_mask_reg;
    assign tcs_engaged      = |slip_mask_reg;
    // The counter only moves when a result enters the result register.
    assign activation_total = activation_count_reg;

endmodule

`default_nettype wire

>>> hdl/pwtc_checker.sv
// Port-level checker for the traction control block and its bind.
`default_nettype none

`include "per_wheel_traction_control_assert.svh"

module pwtc_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire pwtc_pkg::scale_t      scale_out_fl,
    input wire pwtc_pkg::wheel_mask_t slipping_wheels,
    input wire logic                  tcs_engaged,
    input wire pwtc_pkg::count_t      activation_total,
    input wire logic                  pready
);
    import pwtc_pkg::*;

    logic [20:0] held_fields;

    assign held_fields = {scale_out_fl, slipping_wheels};

    // A stalled result stays valid and holds its front-left scale and slip bits.
    `PWTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(held_fields))

    // Engaged flag agrees with the per-wheel slip bits.
    `PWTC_ASSERT_NOW(a_engaged_match, out_valid, tcs_engaged == (slipping_wheels != 4'd0))

    // Activation total moves by at most one per cycle and never goes back.
    `PWTC_ASSERT_NOW(a_total_step, 1'b1, (activation_total - $past(activation_total)) <= 32'd1)

    // The configuration port never stalls.
    `PWTC_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind per_wheel_traction_control pwtc_checker u_pwtc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scale_out_fl     (scale_out_fl),
    .slipping_wheels  (slipping_wheels),
    .tcs_engaged      (tcs_engaged),
    .activation_total (activation_total),
    .pready           (pready)
);

`default_nettype wire
